[src/meanshift_window_measure_macros.svh]
// Assertion macros used by the checker file.
`ifndef MEANSHIFT_WINDOW_MEASURE_MACROS_SVH
`define MEANSHIFT_WINDOW_MEASURE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define MWM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define MWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/msw_pkg.sv]
package msw_pkg;

    localparam int MaxWidth      = 256;
    localparam int MaxHeight     = 256;
    localparam int MaxIterations = 10;
    localparam int MaxRadius     = 63;

    localparam int ColW   = $clog2(MaxWidth);
    localparam int RowW   = $clog2(MaxHeight);
    localparam int AddrW  = ColW + RowW;
    localparam int ItW    = $clog2(MaxIterations + 1);

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_MEASURE = 1'b1;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam int InW  = 33;
    localparam int OutW = 88;

    // Sum widths: mass fits 22 bits, moments add the coordinate bits.
    // The divider width also holds the area weight dividend shifted up by 16.
    localparam int MassW = 24;
    localparam int MomW  = MassW + 16;

endpackage

[src/meanshift_window_measure.sv]
// Mean-shift window measurement on a stored 8-bit probability map.
// Input stream (s_axis): one transfer per item. tuser is the command
// (0 writes a map pixel, 1 measures a particle), tdata packs pos_x, pos_y
// and pixel_value. A write stays in idle and gives no output transfer.
// A measure item runs up to ten mean-shift iterations. Each iteration
// passes a setup state, walks the clipped window one pixel per cycle
// through the single map read port, drains the last read, then, if the
// window mass is nonzero, a shared shift-subtract divider computes each
// coordinate in turn. The item ends with the area weight, which may use
// the divider, the center pixel read and the product.
// Output stream (m_axis): tdata packs new_x, new_y, area, area_gain,
// center_pixel and sample_weight. The result is held in an output
// register until taken. Input transfers continue while it waits, but the
// next measure item holds its own result until the register is free.
// Configuration goes through the APB port: radius at 0x0, image_width at
// 0x4, image_height at 0x8. Write it only while the block is idle.
// Reset restores the register defaults and returns to idle; the map is
// left as it is and must be written before it is measured.
module meanshift_window_measure (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // pos_x[11:0], pos_y[23:12], pixel_value[31:24]
    input  logic        s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,  // new_x[7:0], new_y[15:8], area[37:16],
                                       // area_gain[54:38], center_pixel[62:55],
                                       // sample_weight[86:63]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import msw_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SETUP = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_ACC   = 4'd3;
    localparam logic [3:0] S_DIVX  = 4'd4;
    localparam logic [3:0] S_DIVY  = 4'd5;
    localparam logic [3:0] S_FIN   = 4'd6;
    localparam logic [3:0] S_DIVW  = 4'd7;
    localparam logic [3:0] S_PIX   = 4'd8;
    localparam logic [3:0] S_MUL   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_PIXW  = 4'd11;

    logic [3:0]  r_state;
    logic [5:0]  r_radius;
    logic [8:0]  r_width, r_height;

    // Map memory, one read port with registered data.
    logic [7:0]       r_mem [0:MaxWidth*MaxHeight-1];
    logic [AddrW-1:0] r_rd_addr;
    logic [AddrW-1:0] w_rd_addr;
    logic [7:0]       r_rd_data;
    logic             r_wr_en;
    logic [AddrW-1:0] r_wr_addr;
    logic [7:0]       r_wr_data;

    logic signed [12:0] r_cx, r_cy;
    logic [8:0]  r_x1, r_y0, r_y1, r_x, r_y;
    logic [8:0]  r_ax, r_ay;      // coordinates of the pixel in r_rd_data
    logic        r_acc_v, r_last;
    logic [MassW-1:0] r_m00;
    logic [MomW-1:0]  r_m10, r_m01;
    logic [ItW-1:0]   r_iter;

    // Shared divider: restoring, one quotient bit a cycle.
    logic [MomW-1:0]  r_quo;
    logic [MomW:0]    r_rem;
    logic [MomW-1:0]  r_dvs;
    logic [5:0]       r_dcnt;

    logic [16:0] r_aw;
    logic [23:0] r_sw;
    logic [7:0]  r_pix;
    logic [7:0]  r_nx, r_ny;
    logic [87:0] r_out;
    logic        r_ovalid;

    logic [8:0] w_eff, h_eff;
    logic [5:0] rad_eff;
    logic [27:0] w_full;
    logic [MomW:0] w_trial;

    // Effective configuration after range limits.
    always_comb begin
        w_eff = (r_width == 9'd0) ? 9'd1 : (r_width > 9'(MaxWidth) ? 9'(MaxWidth) : r_width);
        h_eff = (r_height == 9'd0) ? 9'd1 :
                (r_height > 9'(MaxHeight) ? 9'(MaxHeight) : r_height);
        rad_eff = r_radius;
        w_full = 28'(({21'd0, rad_eff, 1'b1}) * ({21'd0, rad_eff, 1'b1})) * 28'd255;
        w_trial = {r_rem[MomW-1:0], r_quo[MomW-1]} - {1'b0, r_dvs};
    end

    // The scan reads the current window pixel; otherwise the held address.
    always_comb begin
        w_rd_addr = (r_state == S_SCAN) ? {r_y[RowW-1:0], r_x[ColW-1:0]} : r_rd_addr;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;
    assign pready        = 1'b1;

    // Configuration readback.
    always_comb begin
        case (paddr[3:2])
            REG_RADIUS: prdata = {26'd0, r_radius};
            REG_WIDTH:  prdata = {23'd0, r_width};
            REG_HEIGHT: prdata = {23'd0, r_height};
            default:    prdata = 32'd0;
        endcase
    end

    // Memory port.
    always_ff @(posedge i_clk) begin
        if (r_wr_en) begin
            r_mem[r_wr_addr] <= r_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_radius <= 6'd8;
            r_width  <= 9'd256;
            r_height <= 9'd256;
            r_wr_en  <= 1'b0;
            r_ovalid <= 1'b0;
            r_acc_v  <= 1'b0;
        end else begin
            r_wr_en <= 1'b0;
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    REG_RADIUS: r_radius <= pwdata[5:0];
                    REG_WIDTH:  r_width  <= pwdata[8:0];
                    REG_HEIGHT: r_height <= pwdata[8:0];
                    default: ;
                endcase
            end
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cx <= 13'(signed'(s_axis_tdata[11:0]));
                        r_cy <= 13'(signed'(s_axis_tdata[23:12]));
                        r_iter <= '0;
                        r_m00 <= '0;
                        if (s_axis_tuser == CMD_WRITE) begin
                            r_wr_en   <= (s_axis_tdata[11:ColW] == '0) &&
                                         (s_axis_tdata[23:12+RowW] == '0);
                            r_wr_addr <= {s_axis_tdata[12+RowW-1:12], s_axis_tdata[ColW-1:0]};
                            r_wr_data <= s_axis_tdata[31:24];
                        end else begin
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    // Clip the window; empty windows give zero mass.
                    logic signed [13:0] lx, hx, ly, hy;
                    lx = 14'(r_cx) - $signed({8'd0, rad_eff});
                    hx = 14'(r_cx) + $signed({8'd0, rad_eff});
                    ly = 14'(r_cy) - $signed({8'd0, rad_eff});
                    hy = 14'(r_cy) + $signed({8'd0, rad_eff});
                    if (lx < 0) lx = 0;
                    if (ly < 0) ly = 0;
                    if (hx > $signed({5'd0, w_eff}) - 14'sd1) hx = $signed({5'd0, w_eff}) - 14'sd1;
                    if (hy > $signed({5'd0, h_eff}) - 14'sd1) hy = $signed({5'd0, h_eff}) - 14'sd1;
                    r_m00 <= '0;
                    r_m10 <= '0;
                    r_m01 <= '0;
                    if (lx > hx || ly > hy) begin
                        r_state <= S_FIN;
                    end else begin
                        r_x1 <= 9'(hx);
                        r_y0 <= 9'(ly); r_y1 <= 9'(hy);
                        r_x  <= 9'(lx); r_y  <= 9'(ly);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Issue one read a cycle and accumulate the previous one.
                    r_ax <= r_x; r_ay <= r_y;
                    r_acc_v <= 1'b1;
                    r_last <= (r_x == r_x1) && (r_y == r_y1);
                    if (r_y == r_y1) begin
                        r_y <= r_y0;
                        r_x <= r_x + 9'd1;
                    end else begin
                        r_y <= r_y + 9'd1;
                    end
                    if ((r_x == r_x1) && (r_y == r_y1)) r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_acc_v && r_last) begin
                        r_acc_v <= 1'b0;
                    end else begin
                        r_acc_v <= 1'b0;
                    end
                    r_state <= S_ACC;
                    if (!r_acc_v) begin
                        r_iter <= r_iter + 1'b1;
                        if (r_m00 == '0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_quo  <= r_m10;
                            r_rem  <= '0;
                            r_dvs  <= MomW'(r_m00);
                            r_dcnt <= 6'(MomW);
                            r_state <= S_DIVX;
                        end
                    end
                end
                S_DIVX, S_DIVY, S_DIVW: begin
                    if (r_dcnt != 6'd0) begin
                        if (!w_trial[MomW]) begin
                            r_rem <= w_trial;
                            r_quo <= {r_quo[MomW-2:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[MomW-1:0], r_quo[MomW-1]};
                            r_quo <= {r_quo[MomW-2:0], 1'b0};
                        end
                        r_dcnt <= r_dcnt - 6'd1;
                    end else if (r_state == S_DIVX) begin
                        r_cx   <= 13'(r_quo[8:0]);
                        r_quo  <= r_m01;
                        r_rem  <= '0;
                        r_dcnt <= 6'(MomW);
                        r_state <= S_DIVY;
                    end else if (r_state == S_DIVY) begin
                        r_cy <= 13'(r_quo[8:0]);
                        r_state <= (r_iter == ItW'(MaxIterations)) ? S_FIN : S_SETUP;
                    end else begin
                        r_aw <= 17'(r_quo);
                        r_state <= S_PIX;
                    end
                end
                S_FIN: begin
                    // Clamp position, then decide the area weight.
                    logic [8:0] fx, fy;
                    logic [MomW-1:0] m5, f4, f1;
                    fx = (r_cx < 0) ? 9'd0 :
                         (r_cx > 13'(w_eff) - 1 ? 9'(w_eff - 9'd1) : 9'(r_cx));
                    fy = (r_cy < 0) ? 9'd0 :
                         (r_cy > 13'(h_eff) - 1 ? 9'(h_eff - 9'd1) : 9'(r_cy));
                    m5 = MomW'(r_m00) * MomW'(5);
                    f4 = MomW'(w_full) << 2;
                    f1 = MomW'(w_full);
                    r_nx <= fx[7:0];
                    r_ny <= fy[7:0];
                    r_rd_addr <= {fy[RowW-1:0], fx[ColW-1:0]};
                    if (m5 > f4) begin
                        r_aw <= 17'd65536;
                        r_state <= S_PIX;
                    end else if (m5 < f1) begin
                        r_aw <= 17'd0;
                        r_state <= S_PIX;
                    end else begin
                        r_quo  <= (m5 - f1) << 16;
                        r_rem  <= '0;
                        r_dvs  <= f1 * MomW'(3);
                        r_dcnt <= 6'(MomW);
                        r_state <= S_DIVW;
                    end
                end
                S_PIX: begin
                    r_state <= S_PIXW;
                end
                S_PIXW: begin
                    r_pix <= r_rd_data;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_sw <= 24'({17'd0, r_pix} * {8'd0, r_aw});
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_out <= {1'b0, r_sw, r_pix, r_aw, r_m00[21:0], r_ny, r_nx};
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // Accumulate the pixel read issued in the previous cycle.
            if (r_acc_v && (r_state == S_SCAN || r_state == S_ACC)) begin
                r_m00 <= r_m00 + MassW'(r_rd_data);
                r_m10 <= r_m10 + MomW'({8'd0, r_ax} * {9'd0, r_rd_data});
                r_m01 <= r_m01 + MomW'({8'd0, r_ay} * {9'd0, r_rd_data});
            end
        end
    end

endmodule

[src/msw_checker.sv]
`include "meanshift_window_measure_macros.svh"
module msw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic        pready
);
    `MWM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "output dropped while stalled")
    `MWM_ASSERT_IMPL(a_weight_max, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tdata[54:38] <= 17'd65536, "area weight above one")
    `MWM_ASSERT_IMPL(a_pready, i_clk, i_rst_n, 1'b1, pready, "pready low")
    `MWM_ASSERT_IMPL(a_zero_mass, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[37:16] == 22'd0,
        m_axis_tdata[54:38] == 17'd0, "nonzero weight for empty window")
endmodule

bind meanshift_window_measure msw_checker u_msw_checker (.*);
